// ----- hw/rtl/rvc_pkg.sv -----
`default_nettype none

package rvc_pkg;

  // Default data memory size in bytes.
  localparam int MEM_BYTES_DEF = 1024;

  // Operation codes carried by each input word.
  typedef enum logic [1:0] {
    OP_EXEC      = 2'd0,
    OP_PRELOAD   = 2'd1,
    OP_READ_REG  = 2'd2,
    OP_READ_BYTE = 2'd3
  } op_t;

  // Instruction decode constants.
  localparam logic [2:0]  F3_ADDSUB = 3'b000;
  localparam logic [6:0]  F7_SUB    = 7'b0100000;
  localparam logic [2:0]  F3_LD     = 3'b011;
  localparam logic [6:0]  OPC_LD    = 7'b0000011;
  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  // Access request from the execute stage to the data memory.
  typedef struct packed {
    logic en;     // access this cycle
    logic we;     // write, else read
    logic dword;  // eight bytes, else a single byte
  } dmem_ctl_t;

  // Row address width of one byte lane of the data memory.
  function automatic int row_bits(input int mem_bytes);
    int rows;
    begin
      rows = (mem_bytes + 7) >> 3;
      return (rows > 1) ? $clog2(rows) : 1;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rvc_regfile.sv -----
`default_nettype none

module rvc_regfile (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        rd_en,
  input  wire logic [4:0]  ra1,
  input  wire logic [4:0]  ra2,
  output logic      [63:0] rd1,
  output logic      [63:0] rd2,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [63:0] wd
);

  logic [63:0] mem [32];
  logic [63:0] q1_r;
  logic [63:0] q2_r;
  logic [31:0] vld_r;
  logic        v1_r;
  logic        v2_r;

  // Register storage with two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      q1_r <= mem[ra1];
      q2_r <= mem[ra2];
    end
  end

  // Written flags: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (rd_en) begin
        v1_r <= vld_r[ra1];
        v2_r <= vld_r[ra2];
      end
    end
  end

  assign rd1 = v1_r ? q1_r : 64'd0;
  assign rd2 = v2_r ? q2_r : 64'd0;

endmodule

`default_nettype wire

// ----- hw/rtl/rvc_dmem.sv -----
`default_nettype none

module rvc_dmem #(
  parameter int MEM_BYTES = rvc_pkg::MEM_BYTES_DEF,
  parameter int AW        = rvc_pkg::row_bits(MEM_BYTES) + 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rvc_pkg::dmem_ctl_t ctl,
  input  wire logic [AW-1:0]     addr,
  input  wire logic [63:0]       wdata,
  output logic      [63:0]       rdata,
  output logic                   busy
);

  localparam int RW        = AW - 3;
  localparam int BANK_ROWS = (MEM_BYTES + 7) / 8;

  logic [2:0]    lane;
  logic [RW-1:0] row0;
  logic [2:0]    lane_r;
  logic [63:0]   q_vec;
  logic [127:0]  rot;
  logic [RW-1:0] clr_row_r;
  logic          clr_busy_r;
  logic          rd_go;

  assign lane  = addr[2:0];
  assign row0  = addr[AW-1:3];
  assign busy  = clr_busy_r;
  assign rd_go = ctl.en && !ctl.we && !clr_busy_r;

  // Clearing pass after reset, one row of all eight lanes per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      if (clr_row_r == RW'(BANK_ROWS - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_row_r <= clr_row_r + 1'b1;
      end
    end
  end

  // Lane offset of the access, kept to realign the read data.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      lane_r <= lane;
    end
  end

  // Eight byte lanes; byte address a lives in lane a mod 8, row a / 8.
  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic [7:0]    mem [BANK_ROWS];
    logic [7:0]    q_r;
    logic [RW-1:0] row_k;
    logic [2:0]    j;
    logic          hit;
    logic          lane_we;
    logic [RW-1:0] lane_wa;
    logic [7:0]    lane_wd;

    // Lanes below the start offset hold bytes of the next row.
    assign row_k   = row0 + RW'((3'(k) < lane) ? 1 : 0);
    assign j       = 3'(k) - lane;
    assign hit     = ctl.dword || (3'(k) == lane);
    assign lane_we = clr_busy_r || (ctl.en && ctl.we && hit);
    assign lane_wa = clr_busy_r ? clr_row_r : row_k;
    assign lane_wd = clr_busy_r ? 8'd0
                   : (ctl.dword ? wdata[{~j, 3'b000} +: 8] : wdata[7:0]);

    always_ff @(posedge clk) begin
      if (lane_we) begin
        mem[lane_wa] <= lane_wd;
      end
      if (rd_go) begin
        q_r <= mem[row_k];
      end
    end

    assign q_vec[(7-k)*8 +: 8] = q_r;
  end

  // Rotate lanes so the byte at the lowest address lands in the top byte.
  assign rot   = {q_vec, q_vec} << {lane_r, 3'b000};
  assign rdata = rot[127:64];

endmodule

`default_nettype wire

// ----- hw/rtl/rv64_add_sub_ld_sd_core.sv -----
`default_nettype none

// Executes add, sub, ld and sd of the 64-bit RISC-V base set, one word per
// instruction, and also preloads and reads data memory bytes and reads
// registers. Each accepted word passes an operand read stage, an execute
// stage that reaches the data memory, and a write-back stage into the output
// register, from which its result is taken. Words enter back to back at one
// per cycle unless a register hazard, the memory clearing pass or a stalled
// output holds them; a word that reads a register written by the word just
// ahead of it waits while that word is in execute or held in write-back,
// since the value reaches it only through the register file write port.
// After reset the data memory is cleared one row of eight bytes per cycle,
// and in_ready stays low until that pass is complete. Doublewords in memory
// are big-endian, and an ld or sd whose last byte falls beyond MEM_BYTES is
// skipped and flagged in out_bad_address.
module rv64_add_sub_ld_sd_core #(
  parameter int MEM_BYTES = rvc_pkg::MEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_instr,
  input  wire logic [9:0]  in_mem_addr,
  input  wire logic [7:0]  in_mem_byte,
  input  wire logic [4:0]  in_reg_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_wrote_reg,
  output logic      [4:0]  out_dest_reg,
  output logic      [63:0] out_reg_value,
  output logic             out_mem_written,
  output logic      [31:0] out_access_addr,
  output logic      [63:0] out_store_value,
  output logic      [7:0]  out_read_byte,
  output logic             out_halted,
  output logic             out_bad_address
);

  localparam int AW = rvc_pkg::row_bits(MEM_BYTES) + 3;

  typedef enum logic [2:0] {
    CLS_HALT,
    CLS_ADD,
    CLS_SUB,
    CLS_LD,
    CLS_SD
  } cls_t;

  // Handshake and stage movement.
  logic acc;
  logic adv_x;
  logic adv_w;
  logic hazard;
  logic dm_busy;

  // Operand read (accept) side.
  logic [4:0]  rd1_addr;
  logic [4:0]  rd2_addr;
  logic [63:0] rf_rd1;
  logic [63:0] rf_rd2;

  // Execute stage registers.
  logic          x_vld_r;
  rvc_pkg::op_t  x_op_r;
  logic [31:0]   x_instr_r;
  logic [9:0]    x_mem_addr_r;
  logic [7:0]    x_mem_byte_r;
  logic          x_fwd1_r;
  logic          x_fwd2_r;
  logic [63:0]   x_fwd_data_r;
  logic          halt_r;

  // Execute stage logic.
  cls_t                x_cls;
  logic [4:0]          x_rd;
  logic                x_wr_cand;
  logic [63:0]         x_a;
  logic [63:0]         x_b;
  logic [63:0]         x_imm;
  logic [63:0]         x_ea;
  logic                x_ea_bad;
  logic [31:0]         x_maddr;
  logic                x_maddr_ok;
  logic                halt_nxt;
  logic                x_wrote;
  logic [4:0]          x_dest;
  logic [63:0]         x_val;
  logic                x_is_ld;
  logic                x_mwr;
  logic [31:0]         x_addr;
  logic [63:0]         x_sval;
  logic                x_rbyte;
  logic                x_bad;
  rvc_pkg::dmem_ctl_t  x_dm_ctl;
  rvc_pkg::dmem_ctl_t  dm_ctl;
  logic [AW-1:0]       dm_addr;
  logic [63:0]         dm_wdata;
  logic [63:0]         dm_rdata;

  // Write-back stage registers.
  logic        w_vld_r;
  logic        w_wrote_r;
  logic [4:0]  w_rd_r;
  logic [63:0] w_val_r;
  logic        w_ld_r;
  logic        w_mwr_r;
  logic [31:0] w_addr_r;
  logic [63:0] w_sval_r;
  logic        w_rbyte_r;
  logic        w_halted_r;
  logic        w_bad_r;
  logic [63:0] w_val;
  logic        w_pend;

  // Output register.
  logic        o_vld_r;
  logic        o_wrote_r;
  logic [4:0]  o_rd_r;
  logic [63:0] o_val_r;
  logic        o_mwr_r;
  logic [31:0] o_addr_r;
  logic [63:0] o_sval_r;
  logic [7:0]  o_rbyte_r;
  logic        o_halted_r;
  logic        o_bad_r;

  // Stage movement: output register, then write-back, then execute.
  assign adv_w = w_vld_r && (!o_vld_r || out_ready);
  assign adv_x = x_vld_r && (!w_vld_r || adv_w);
  assign acc   = in_valid && in_ready;

  // Register ports read at acceptance.
  assign rd1_addr = (rvc_pkg::op_t'(in_operation) == rvc_pkg::OP_READ_REG)
                  ? in_reg_index : in_instr[19:15];
  assign rd2_addr = in_instr[24:20];

  // A read must wait for a pending write that would land after it.
  assign w_pend = w_vld_r && w_wrote_r && !adv_w;
  assign hazard = (x_wr_cand && ((x_rd == rd1_addr) || (x_rd == rd2_addr)))
               || (w_pend && ((w_rd_r == rd1_addr) || (w_rd_r == rd2_addr)));
  assign in_ready = !dm_busy && (!x_vld_r || adv_x) && !hazard;

  rvc_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (acc),
    .ra1   (rd1_addr),
    .ra2   (rd2_addr),
    .rd1   (rf_rd1),
    .rd2   (rf_rd2),
    .we    (adv_w && w_wrote_r),
    .wa    (w_rd_r),
    .wd    (w_val)
  );

  // Execute stage capture, with forwarding of a write on the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else if (acc) begin
      x_vld_r <= 1'b1;
    end else if (adv_x) begin
      x_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x_op_r       <= rvc_pkg::op_t'(in_operation);
      x_instr_r    <= in_instr;
      x_mem_addr_r <= in_mem_addr;
      x_mem_byte_r <= in_mem_byte;
      x_fwd1_r     <= adv_w && w_wrote_r && (w_rd_r == rd1_addr);
      x_fwd2_r     <= adv_w && w_wrote_r && (w_rd_r == rd2_addr);
      x_fwd_data_r <= w_val;
    end
  end

  // Instruction class, halt word first.
  always_comb begin
    if (x_instr_r == rvc_pkg::HALT_WORD) begin
      x_cls = CLS_HALT;
    end else if (x_instr_r[14:12] == rvc_pkg::F3_ADDSUB) begin
      x_cls = (x_instr_r[31:25] == rvc_pkg::F7_SUB) ? CLS_SUB : CLS_ADD;
    end else if ((x_instr_r[14:12] == rvc_pkg::F3_LD) &&
                 (x_instr_r[6:0] == rvc_pkg::OPC_LD)) begin
      x_cls = CLS_LD;
    end else begin
      x_cls = CLS_SD;
    end
  end

  assign x_rd      = x_instr_r[11:7];
  assign x_wr_cand = x_vld_r && (x_op_r == rvc_pkg::OP_EXEC) && (x_rd != 5'd0)
                  && ((x_cls == CLS_ADD) || (x_cls == CLS_SUB) || (x_cls == CLS_LD));

  // Operands and effective address.
  assign x_a   = x_fwd1_r ? x_fwd_data_r : rf_rd1;
  assign x_b   = x_fwd2_r ? x_fwd_data_r : rf_rd2;
  assign x_imm = (x_cls == CLS_LD)
               ? {{52{x_instr_r[31]}}, x_instr_r[31:20]}
               : {{52{x_instr_r[31]}}, x_instr_r[31:25], x_instr_r[11:7]};
  assign x_ea       = x_a + x_imm;
  assign x_ea_bad   = x_ea > 64'(MEM_BYTES - 8);
  assign x_maddr    = 32'(x_mem_addr_r);
  assign x_maddr_ok = x_maddr < 32'(MEM_BYTES);

  // Result fields and memory request of the word in execute.
  always_comb begin
    halt_nxt = halt_r;
    x_wrote  = 1'b0;
    x_dest   = 5'd0;
    x_val    = 64'd0;
    x_is_ld  = 1'b0;
    x_mwr    = 1'b0;
    x_addr   = 32'd0;
    x_sval   = 64'd0;
    x_rbyte  = 1'b0;
    x_bad    = 1'b0;
    x_dm_ctl = '0;
    dm_addr  = x_maddr[AW-1:0];
    dm_wdata = {56'd0, x_mem_byte_r};
    case (x_op_r)
      rvc_pkg::OP_EXEC: begin
        if (!halt_r) begin
          case (x_cls)
            CLS_HALT: begin
              halt_nxt = 1'b1;
            end
            CLS_ADD, CLS_SUB: begin
              x_wrote = (x_rd != 5'd0);
              x_dest  = x_wrote ? x_rd : 5'd0;
              if (x_wrote) begin
                x_val = (x_cls == CLS_SUB) ? (x_a - x_b) : (x_a + x_b);
              end
            end
            CLS_LD: begin
              x_addr  = x_ea[31:0];
              dm_addr = x_ea[AW-1:0];
              if (x_ea_bad) begin
                x_bad = 1'b1;
              end else begin
                x_wrote  = (x_rd != 5'd0);
                x_dest   = x_wrote ? x_rd : 5'd0;
                x_is_ld  = x_wrote;
                x_dm_ctl = '{en: x_wrote, we: 1'b0, dword: 1'b1};
              end
            end
            default: begin
              x_addr   = x_ea[31:0];
              dm_addr  = x_ea[AW-1:0];
              dm_wdata = x_b;
              if (x_ea_bad) begin
                x_bad = 1'b1;
              end else begin
                x_mwr    = 1'b1;
                x_sval   = x_b;
                x_dm_ctl = '{en: 1'b1, we: 1'b1, dword: 1'b1};
              end
            end
          endcase
        end
      end
      rvc_pkg::OP_PRELOAD: begin
        if (x_maddr_ok) begin
          x_dm_ctl = '{en: 1'b1, we: 1'b1, dword: 1'b0};
        end
      end
      rvc_pkg::OP_READ_REG: begin
        x_val = x_a;
      end
      default: begin
        if (x_maddr_ok) begin
          x_rbyte  = 1'b1;
          x_dm_ctl = '{en: 1'b1, we: 1'b0, dword: 1'b0};
        end
      end
    endcase
  end

  // Memory is touched only on the edge the word leaves execute.
  always_comb begin
    dm_ctl    = x_dm_ctl;
    dm_ctl.en = x_dm_ctl.en && adv_x;
  end

  rvc_dmem #(
    .MEM_BYTES (MEM_BYTES),
    .AW        (AW)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dm_ctl),
    .addr  (dm_addr),
    .wdata (dm_wdata),
    .rdata (dm_rdata),
    .busy  (dm_busy)
  );

  // Halt flag and write-back stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r  <= 1'b0;
      w_vld_r <= 1'b0;
    end else begin
      if (adv_x) begin
        halt_r <= halt_nxt;
      end
      if (adv_x) begin
        w_vld_r <= 1'b1;
      end else if (adv_w) begin
        w_vld_r <= 1'b0;
      end
    end
  end

  // Write-back stage payload.
  always_ff @(posedge clk) begin
    if (adv_x) begin
      w_wrote_r  <= x_wrote;
      w_rd_r     <= x_dest;
      w_val_r    <= x_val;
      w_ld_r     <= x_is_ld;
      w_mwr_r    <= x_mwr;
      w_addr_r   <= x_addr;
      w_sval_r   <= x_sval;
      w_rbyte_r  <= x_rbyte;
      w_halted_r <= halt_nxt;
      w_bad_r    <= x_bad;
    end
  end

  // A load takes its value from the memory read data.
  assign w_val = w_ld_r ? dm_rdata : w_val_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv_w) begin
      o_vld_r <= 1'b1;
    end else if (out_ready) begin
      o_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_w) begin
      o_wrote_r  <= w_wrote_r;
      o_rd_r     <= w_rd_r;
      o_val_r    <= w_val;
      o_mwr_r    <= w_mwr_r;
      o_addr_r   <= w_addr_r;
      o_sval_r   <= w_sval_r;
      o_rbyte_r  <= w_rbyte_r ? dm_rdata[63:56] : 8'd0;
      o_halted_r <= w_halted_r;
      o_bad_r    <= w_bad_r;
    end
  end

  assign out_valid       = o_vld_r;
  assign out_wrote_reg   = o_wrote_r;
  assign out_dest_reg    = o_rd_r;
  assign out_reg_value   = o_val_r;
  assign out_mem_written = o_mwr_r;
  assign out_access_addr = o_addr_r;
  assign out_store_value = o_sval_r;
  assign out_read_byte   = o_rbyte_r;
  assign out_halted      = o_halted_r;
  assign out_bad_address = o_bad_r;

  // x0 is never written.
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (adv_w && w_wrote_r) |-> (w_rd_r != 5'd0))
    else $error("register write aimed at x0");

  // Once halted, the core stays halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared");

  // A skipped access changes no state.
  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (w_vld_r && w_bad_r) |-> (!w_wrote_r && !w_mwr_r))
    else $error("out-of-range access wrote state");

  // A word writes a register or memory, never both.
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    (w_vld_r && w_wrote_r) |-> !w_mwr_r)
    else $error("word wrote both register and memory");

endmodule

`default_nettype wire

// ----- tb/rv64_add_sub_ld_sd_core_test.sv -----
`default_nettype none

module rv64_add_sub_ld_sd_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rvc_pkg::*;

  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam int RANDOM_WORDS = 1750;
  localparam int SQUEEZE_AFTER = 400;
  localparam int SQUEEZE_CYCLES = 160;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 600_000;

  // One input word as the driver applies it.
  typedef struct packed {
    op_t         op;
    logic [31:0] instr;
    logic [9:0]  addr;
    logic [7:0]  data;
    logic [4:0]  ridx;
  } word_t;

  // One result word, field for field as the ports carry it.
  typedef struct packed {
    logic        wrote;
    logic [4:0]  dest;
    logic [63:0] rval;
    logic        mwr;
    logic [31:0] eaddr;
    logic [63:0] sval;
    logic [7:0]  rbyte;
    logic        halted;
    logic        bad;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [31:0] in_instr = '0;
  logic [9:0]  in_mem_addr = '0;
  logic [7:0]  in_mem_byte = '0;
  logic [4:0]  in_reg_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_wrote_reg;
  logic [4:0]  out_dest_reg;
  logic [63:0] out_reg_value;
  logic        out_mem_written;
  logic [31:0] out_access_addr;
  logic [63:0] out_store_value;
  logic [7:0]  out_read_byte;
  logic        out_halted;
  logic        out_bad_address;

  word_t       word_queue[$];
  outcome_t    core_results_due[$];

  // Architectural copy of the core state.
  logic [63:0] arch_regs [0:31];
  logic [7:0]  arch_mem [0:MEM_BYTES-1];
  logic        arch_halted;

  logic        in_fire = 1'b0;
  int unsigned ready_hold = 0;
  int unsigned valid_hold = 0;
  bit          squeeze_done = 1'b0;
  int unsigned words_out = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  rv64_add_sub_ld_sd_core #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_instr(in_instr), .in_mem_addr(in_mem_addr),
    .in_mem_byte(in_mem_byte), .in_reg_index(in_reg_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_wrote_reg(out_wrote_reg), .out_dest_reg(out_dest_reg),
    .out_reg_value(out_reg_value), .out_mem_written(out_mem_written),
    .out_access_addr(out_access_addr), .out_store_value(out_store_value),
    .out_read_byte(out_read_byte), .out_halted(out_halted),
    .out_bad_address(out_bad_address)
  );

  always #5 clk = ~clk;

  // Applies one word to the architectural state and returns the result it causes.
  function automatic outcome_t retire_word(input word_t w);
    outcome_t    res;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] imm;
    logic [63:0] ea;
    logic [63:0] v;
    logic        is_ld;
    logic        do_write;
    res = '0;
    do_write = 1'b0;
    v = '0;
    case (w.op)
      OP_EXEC: begin
        f3 = w.instr[14:12];
        f7 = w.instr[31:25];
        rd = w.instr[11:7];
        a = arch_regs[w.instr[19:15]];
        b = arch_regs[w.instr[24:20]];
        if (arch_halted) begin
          // A halted core ignores every further instruction.
        end else if (w.instr == HALT_WORD) begin
          arch_halted = 1'b1;
        end else if (f3 == F3_ADDSUB) begin
          v = (f7 == F7_SUB) ? a - b : a + b;
          do_write = 1'b1;
        end else begin
          is_ld = (f3 == F3_LD) && (w.instr[6:0] == OPC_LD);
          imm = is_ld ? {{52{w.instr[31]}}, w.instr[31:20]}
                      : {{52{w.instr[31]}}, w.instr[31:25], w.instr[11:7]};
          ea = a + imm;
          res.eaddr = ea[31:0];
          // The last byte of the doubleword must still lie inside memory.
          if (ea > 64'(MEM_BYTES - 8)) begin
            res.bad = 1'b1;
          end else if (is_ld) begin
            for (int k = 0; k < 8; k++) v = {v[55:0], arch_mem[int'(ea[31:0]) + k]};
            do_write = 1'b1;
          end else begin
            for (int k = 0; k < 8; k++) arch_mem[int'(ea[31:0]) + k] = b[63 - 8 * k -: 8];
            res.mwr = 1'b1;
            res.sval = b;
          end
        end
        // Writes to x0 are dropped and leave no trace in the result.
        if (do_write && rd != 5'd0) begin
          arch_regs[rd] = v;
          res.wrote = 1'b1;
          res.dest = rd;
          res.rval = v;
        end
      end
      OP_PRELOAD: begin
        if (int'(w.addr) < MEM_BYTES) arch_mem[w.addr] = w.data;
      end
      OP_READ_REG: begin
        res.rval = (w.ridx == 5'd0) ? 64'd0 : arch_regs[w.ridx];
      end
      default: begin
        if (int'(w.addr) < MEM_BYTES) res.rbyte = arch_mem[w.addr];
      end
    endcase
    res.halted = arch_halted;
    return res;
  endfunction

  // Instruction encoders for the forms the core decodes.
  function automatic logic [31:0] enc_ld(input int imm, input logic [4:0] rs1,
                                         input logic [4:0] rd);
    return {imm[11:0], rs1, F3_LD, rd, OPC_LD};
  endfunction

  function automatic logic [31:0] enc_sd(input int imm, input logic [4:0] rs1,
                                         input logic [4:0] rs2);
    logic [2:0] f3;
    logic [6:0] opc;
    f3 = 3'($urandom_range(1, 7));
    opc = 7'($urandom);
    if (f3 == F3_LD && opc == OPC_LD) opc = opc ^ 7'h40;
    return {imm[11:5], rs2, rs1, f3, imm[4:0], opc};
  endfunction

  function automatic logic [31:0] enc_alu(input bit sub, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2);
    logic [6:0] f7;
    f7 = 7'($urandom);
    if (sub) f7 = F7_SUB;
    else if (f7 == F7_SUB) f7 = f7 ^ 7'h01;
    return {f7, rs2, rs1, F3_ADDSUB, rd, 7'($urandom)};
  endfunction

  // Word builders; fields that the operation does not use carry noise.
  task automatic queue_word(input op_t op, input logic [31:0] ins, input logic [9:0] a,
                            input logic [7:0] d, input logic [4:0] r);
    word_queue.push_back('{op: op, instr: ins, addr: a, data: d, ridx: r});
  endtask

  task automatic queue_exec(input logic [31:0] ins);
    // Only the tail of the run is allowed to halt the core.
    if (ins == HALT_WORD) ins[12] = 1'b0;
    queue_word(OP_EXEC, ins, 10'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic queue_preload(input logic [9:0] a, input logic [7:0] d);
    queue_word(OP_PRELOAD, $urandom, a, d, 5'($urandom));
  endtask

  task automatic queue_read_reg(input logic [4:0] r);
    queue_word(OP_READ_REG, $urandom, 10'($urandom), 8'($urandom), r);
  endtask

  task automatic queue_read_byte(input logic [9:0] a);
    queue_word(OP_READ_BYTE, $urandom, a, 8'($urandom), 5'($urandom));
  endtask

  // Idle length for either side: mostly none or short, a few long, and none
  // at all during one stretch out of every four.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (cycle_count[8:7] == 2'b00) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int          base;
    int          target;
    int          span;
    int          n_ops;
    logic [4:0]  rb;
    logic [4:0]  rd;
    logic [9:0]  row;
    logic [63:0] bv;

    // Directed words: boundaries of the address check, x0 handling, wraps.
    queue_read_byte(10'd1023);
    queue_read_reg(5'd31);
    queue_preload(10'd1016, 8'hFF);
    queue_preload(10'd1023, 8'h01);
    queue_exec(enc_ld(1016, 5'd0, 5'd1));
    queue_exec(enc_ld(1017, 5'd0, 5'd2));
    queue_exec(enc_ld(-1, 5'd0, 5'd3));
    queue_exec(enc_ld(1016, 5'd0, 5'd0));
    queue_exec(enc_ld(0, 5'd1, 5'd8));
    queue_exec(enc_alu(1'b0, 5'd4, 5'd1, 5'd1));
    queue_exec(enc_alu(1'b1, 5'd5, 5'd0, 5'd1));
    queue_exec(enc_alu(1'b0, 5'd0, 5'd1, 5'd5));
    queue_exec(enc_alu(1'b1, 5'd7, 5'd1, 5'd1));
    queue_exec(enc_sd(0, 5'd0, 5'd1));
    queue_exec(enc_sd(1016, 5'd0, 5'd5));
    queue_exec(enc_sd(1017, 5'd0, 5'd1));
    queue_exec(enc_sd(-8, 5'd0, 5'd1));
    queue_exec(enc_ld(0, 5'd0, 5'd6));
    queue_read_byte(10'd0);
    queue_read_byte(10'd1023);
    queue_read_reg(5'd4);
    queue_read_reg(5'd0);
    queue_read_reg(5'd6);

    // Random words, mostly pointer sequences that reach real memory.
    span = word_queue.size() + RANDOM_WORDS;
    while (word_queue.size() < span) begin
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          // Load a small pointer into rb, then access memory through it.
          base = $urandom_range(0, MEM_BYTES - 8);
          bv = 64'(base);
          row = 10'(8 * $urandom_range(0, MEM_BYTES / 8 - 1));
          rb = 5'($urandom_range(1, 31));
          for (int k = 0; k < 8; k++) queue_preload(row + 10'(k), bv[63 - 8 * k -: 8]);
          queue_exec(enc_ld(int'(row), 5'd0, rb));
          n_ops = $urandom_range(2, 6);
          for (int j = 0; j < n_ops; j++) begin
            if ($urandom_range(0, 9) == 0) target = $urandom_range(MEM_BYTES - 7, MEM_BYTES + 60);
            else target = $urandom_range(0, MEM_BYTES - 8);
            rd = 5'($urandom);
            if (rd == rb) rd = 5'd0;
            case ($urandom_range(0, 3))
              0: queue_exec(enc_sd(target - base, rb, 5'($urandom)));
              1: queue_exec(enc_ld(target - base, rb, rd));
              2: queue_exec(enc_alu($urandom_range(0, 1) == 1, rd, 5'($urandom), 5'($urandom)));
              default: queue_read_byte(10'(target));
            endcase
          end
        end
        [45:64]: begin
          // Accesses based on x0 with any immediate, about three quarters out of range.
          if ($urandom_range(0, 1) == 1) queue_exec(enc_ld($urandom, 5'd0, 5'($urandom)));
          else queue_exec(enc_sd($urandom, 5'd0, 5'($urandom)));
        end
        [65:79]: queue_exec(enc_alu($urandom_range(0, 1) == 1, 5'($urandom), 5'($urandom),
                                    5'($urandom)));
        [80:87]: queue_preload(10'($urandom), 8'($urandom));
        [88:93]: queue_read_reg(5'($urandom));
        [94:97]: queue_read_byte(10'($urandom));
        default: queue_exec($urandom);
      endcase
    end

    // Halt, then show that execution stops while preloads and reads go on.
    queue_word(OP_EXEC, HALT_WORD, 10'($urandom), 8'($urandom), 5'($urandom));
    queue_exec(enc_alu(1'b0, 5'd9, 5'd1, 5'd1));
    queue_exec(enc_sd(0, 5'd0, 5'd1));
    queue_word(OP_EXEC, HALT_WORD, 10'($urandom), 8'($urandom), 5'($urandom));
    queue_preload(10'd5, 8'hA5);
    queue_read_byte(10'd5);
    queue_read_reg(5'd1);
    queue_read_reg(5'd9);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_valid || core_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Sender: offers the next word after its gap, holding it until taken.
  always @(negedge clk) begin : sender
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      valid_hold <= 0;
    end else if (!in_valid || in_fire) begin
      if (valid_hold != 0) begin
        in_valid <= 1'b0;
        valid_hold <= valid_hold - 1;
      end else if (word_queue.size() != 0) begin
        w = word_queue.pop_front();
        in_operation <= w.op;
        in_instr <= w.instr;
        in_mem_addr <= w.addr;
        in_mem_byte <= w.data;
        in_reg_index <= w.ridx;
        in_valid <= 1'b1;
        valid_hold <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up.
  always @(negedge clk) begin : receiver
    int unsigned g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!squeeze_done && words_out >= SQUEEZE_AFTER) begin
      out_ready <= 1'b0;
      ready_hold <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else begin
      g = pick_gap();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        ready_hold <= g - 1;
      end
    end
  end

  // Monitor: predicts each accepted word and checks each result word.
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
      arch_halted = 1'b0;
      for (int i = 0; i < 32; i++) arch_regs[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        core_results_due.push_back(retire_word('{op: op_t'(in_operation), instr: in_instr,
                                                 addr: in_mem_addr, data: in_mem_byte,
                                                 ridx: in_reg_index}));
      if (out_valid && out_ready) begin
        words_out <= words_out + 1;
        got = '{wrote: out_wrote_reg, dest: out_dest_reg, rval: out_reg_value,
                mwr: out_mem_written, eaddr: out_access_addr, sval: out_store_value,
                rbyte: out_read_byte, halted: out_halted, bad: out_bad_address};
        if (core_results_due.size() == 0) begin
          report_mismatch("result word with none outstanding", 64'(got.rval), '0);
        end else begin
          want = core_results_due.pop_front();
          if (got.wrote !== want.wrote) report_mismatch("wrote_reg", 64'(got.wrote), 64'(want.wrote));
          if (got.dest !== want.dest) report_mismatch("dest_reg", 64'(got.dest), 64'(want.dest));
          if (got.rval !== want.rval) report_mismatch("reg_value", got.rval, want.rval);
          if (got.mwr !== want.mwr) report_mismatch("mem_written", 64'(got.mwr), 64'(want.mwr));
          if (got.eaddr !== want.eaddr)
            report_mismatch("access_addr", 64'(got.eaddr), 64'(want.eaddr));
          if (got.sval !== want.sval) report_mismatch("store_value", got.sval, want.sval);
          if (got.rbyte !== want.rbyte)
            report_mismatch("read_byte", 64'(got.rbyte), 64'(want.rbyte));
          if (got.halted !== want.halted)
            report_mismatch("halted", 64'(got.halted), 64'(want.halted));
          if (got.bad !== want.bad) report_mismatch("bad_address", 64'(got.bad), 64'(want.bad));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/rvc_pkg.sv
hw/rtl/rvc_regfile.sv
hw/rtl/rvc_dmem.sv
hw/rtl/rv64_add_sub_ld_sd_core.sv
tb/rv64_add_sub_ld_sd_core_test.sv
